// ===== design/assert_macros.svh =====
// Assertion helper macros used by the deframer queue module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that a condition implies another one in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Assert that a condition implies another one in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== design/mbdf_pkg.sv =====
// ----------------------------------------------------------------------------
// mbdf_pkg
// Types, codes and the CRC byte step for the MacBinary stream deframer.
// ----------------------------------------------------------------------------
package mbdf_pkg;

  typedef enum logic [2:0] {
    ST_HEADER = 3'd0,
    ST_DATA   = 3'd1,
    ST_RSRC   = 3'd2,
    ST_RAW    = 3'd3,
    ST_DONE   = 3'd4
  } stage_t;

  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_RSRC = 2'd2;
  localparam logic [1:0] KIND_RAW  = 2'd3;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // one result item
  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  stream_kind;
    logic        fork_last;
    logic        header_end;
    logic        header_valid;
    logic        version_two;
    logic [31:0] data_length;
    logic [31:0] resource_length;
    logic [7:0]  secondary_flags;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== design/mbdf_front.sv =====
// ----------------------------------------------------------------------------
// mbdf_front
// Classifies each byte against the header and fork state; emits result items.
// ----------------------------------------------------------------------------
module mbdf_front
  import mbdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        dis,
  input  logic        take,
  input  logic [7:0]  b,
  input  logic        first,
  input  logic        last,
  output logic        res_vld,
  output result_t     res
);

  stage_t      stage_r, stage_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        ok_r, ok_nxt;
  logic [15:0] rcrc_r, rcrc_nxt;
  logic [7:0]  ver_r, ver_nxt, minv_r, minv_nxt, flg_r, flg_nxt;
  logic [31:0] dlen_r, dlen_nxt, rlen_r, rlen_nxt;
  logic [32:0] off_r, off_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= ST_HEADER; pos_r <= '0; crc_r <= '0; ok_r <= 1'b1;
      rcrc_r <= '0; ver_r <= '0; minv_r <= '0; flg_r <= '0;
      dlen_r <= '0; rlen_r <= '0; off_r <= '0;
    end else if (take) begin
      stage_r <= stage_nxt; pos_r <= pos_nxt; crc_r <= crc_nxt; ok_r <= ok_nxt;
      rcrc_r <= rcrc_nxt; ver_r <= ver_nxt; minv_r <= minv_nxt; flg_r <= flg_nxt;
      dlen_r <= dlen_nxt; rlen_r <= rlen_nxt; off_r <= off_nxt;
    end
  end

  stage_t      s;
  logic [7:0]  p;
  logic [15:0] c;
  logic        ok, crc_ok, newer, valid, v2;
  logic [31:0] len;
  logic [32:0] pad, off1;

  always_comb begin
    // clear stream state on the first byte of a file
    s = first ? ST_HEADER : stage_r;
    p = first ? 8'd0 : pos_r;
    c = first ? 16'd0 : crc_r;
    ok = first ? 1'b1 : ok_r;
    rcrc_nxt = first ? 16'd0 : rcrc_r;
    ver_nxt = first ? 8'd0 : ver_r;
    minv_nxt = first ? 8'd0 : minv_r;
    flg_nxt = first ? 8'd0 : flg_r;
    dlen_nxt = first ? 32'd0 : dlen_r;
    rlen_nxt = first ? 32'd0 : rlen_r;
    off_nxt = first ? 33'd0 : off_r;
    stage_nxt = s; pos_nxt = p; crc_nxt = c; ok_nxt = ok;
    res = '0;
    res.out_byte = b;
    res_vld = 1'b0;
    crc_ok = 1'b0; newer = 1'b0; valid = 1'b0; v2 = 1'b0;
    len = '0; pad = '0; off1 = '0;
    if (dis) begin
      res_vld = 1'b1;
      res.stream_kind = KIND_RAW;
    end else begin
      unique case (s)
        ST_HEADER: begin
          res_vld = 1'b1;
          res.stream_kind = KIND_HDR;
          if (p < 8'd124) crc_nxt = crc_byte(c, b);
          if (p == 8'd0 || p == 8'd74 || p == 8'd82) begin
            if (b != 8'd0) ok_nxt = 1'b0;
          end else if (p == 8'd1) begin
            if (b < 8'd1 || b >= 8'd65) ok_nxt = 1'b0;
          end else if (p >= 8'd83 && p <= 8'd86) begin
            dlen_nxt = {dlen_nxt[23:0], b};
          end else if (p >= 8'd87 && p <= 8'd90) begin
            rlen_nxt = {rlen_nxt[23:0], b};
          end else if (p == 8'd101) begin
            flg_nxt = b;
          end else if (p == 8'd122) begin
            ver_nxt = b;
          end else if (p == 8'd123) begin
            minv_nxt = b;
          end else if (p == 8'd124 || p == 8'd125) begin
            rcrc_nxt = {rcrc_nxt[7:0], b};
          end
          pos_nxt = p + 8'd1;
          if (p >= 8'd127) begin
            crc_ok = crc_nxt == rcrc_nxt;
            newer = crc_ok && ver_nxt > 8'd128;
            valid = ok_nxt && !(newer && minv_nxt > 8'd129);
            v2 = valid && newer;
            res.header_end = 1'b1;
            res.header_valid = valid;
            res.version_two = v2;
            res.data_length = dlen_nxt;
            res.resource_length = rlen_nxt;
            res.secondary_flags = v2 ? flg_nxt : 8'd0;
            off_nxt = '0;
            if (!valid) stage_nxt = ST_RAW;
            else if (dlen_nxt != 0) stage_nxt = ST_DATA;
            else if (rlen_nxt != 0) stage_nxt = ST_RSRC;
            else stage_nxt = ST_DONE;
          end else if (last) begin
            res.header_end = 1'b1;
            stage_nxt = ST_RAW;
          end
        end
        ST_DATA, ST_RSRC: begin
          len = (s == ST_DATA) ? dlen_nxt : rlen_nxt;
          pad = ({1'b0, len} + 33'd127) & ~33'd127;
          off1 = off_nxt + 33'd1;
          if (off_nxt < {1'b0, len}) begin
            res_vld = 1'b1;
            res.stream_kind = (s == ST_DATA) ? KIND_DATA : KIND_RSRC;
            res.fork_last = off1 == {1'b0, len};
          end
          off_nxt = off1;
          if (off1 >= pad) begin
            off_nxt = '0;
            if (s == ST_DATA && rlen_nxt != 0) stage_nxt = ST_RSRC;
            else stage_nxt = ST_DONE;
          end
        end
        ST_RAW: begin
          res_vld = 1'b1;
          res.stream_kind = KIND_RAW;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/mbdf_queue.sv =====
// ----------------------------------------------------------------------------
// mbdf_queue
// Two-entry result queue between classification and the output port.
// ----------------------------------------------------------------------------
module mbdf_queue
  import mbdf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t din,
  output logic    full,
  output logic    out_vld,
  input  logic    pop,
  output result_t dout
);
  `include "assert_macros.svh"

  result_t    mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_pop;

  assign full    = cnt_r == 2'd2;
  assign out_vld = cnt_r != 2'd0;
  assign dout    = mem_r[rp_r];
  assign do_pop  = pop && out_vld;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, do_pop};
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, !full || do_pop)
  `ASSERT_IMPLIES(a_cnt_range, clk, rst_n, 1'b1, cnt_r != 2'd3)
  `ASSERT_NEXT(a_hold, clk, rst_n, out_vld && !pop && !push, out_vld && $stable(dout))
endmodule

// ===== design/macbinary_stream_deframer.sv =====
// ----------------------------------------------------------------------------
// macbinary_stream_deframer
// Detects a MacBinary header and splits the stream into data/resource forks.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while in_stall is low. The front classifier
// checks the 128-byte header (CRC-16 over bytes 0..123, fixed fields,
// version bytes) and tracks fork offsets for each byte; results go into a
// two-entry queue that drives the output port, so in_stall rises only when
// that queue is full. The queue registers each item for the output port.
// Padding and trailing bytes produce no item. disable_detection passes every
// byte raw; write it only while the block is idle.
module macbinary_stream_deframer
  import mbdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_in_byte,
  input  logic        in_first_of_file,
  input  logic        in_last_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_out_byte,
  output logic [1:0]  out_stream_kind,
  output logic        out_fork_last,
  output logic        out_header_end,
  output logic        out_header_valid,
  output logic        out_version_two,
  output logic [31:0] out_data_length,
  output logic [31:0] out_resource_length,
  output logic [7:0]  out_secondary_flags
);

  logic    dis_r;
  logic    take, res_vld, full;
  result_t res, q;

  // hold the config bit
  always_ff @(posedge clk) begin
    if (!rst_n) dis_r <= 1'b0;
    else if (cfg_we) dis_r <= cfg_wdata;
  end

  assign in_stall = full;
  assign take     = in_valid && !full;

  mbdf_front u_front (
    .clk, .rst_n, .dis(dis_r), .take,
    .b(in_in_byte), .first(in_first_of_file), .last(in_last_of_file),
    .res_vld, .res
  );

  mbdf_queue u_queue (
    .clk, .rst_n, .push(take && res_vld), .din(res), .full,
    .out_vld(out_valid), .pop(!out_stall), .dout(q)
  );

  assign out_out_byte        = q.out_byte;
  assign out_stream_kind     = q.stream_kind;
  assign out_fork_last       = q.fork_last;
  assign out_header_end      = q.header_end;
  assign out_header_valid    = q.header_valid;
  assign out_version_two     = q.version_two;
  assign out_data_length     = q.data_length;
  assign out_resource_length = q.resource_length;
  assign out_secondary_flags = q.secondary_flags;

endmodule

// ===== bench/tb_macbinary_stream_deframer.sv =====
// ----------------------------------------------------------------------------
// tb_macbinary_stream_deframer
// Self-checking bench: drives files (MacBinary envelopes with good and bad
// CRC, rejected versions, short files, raw files) through the deframer with
// random idling, predicts every routed item and compares it field by field.
// ----------------------------------------------------------------------------
module tb_macbinary_stream_deframer;
  import mbdf_pkg::*;

  // Expected-item store and checker.
  class route_scoreboard;
    result_t pending[$];
    int errors;

    function void note_accept(result_t r);
      pending.push_back(r);
    endfunction

    function void check_item(result_t got);
      result_t exp;
      if (pending.size() == 0) begin
        $error("unexpected item: out_byte %0h", got.out_byte);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.out_byte !== exp.out_byte) begin
        $error("out_byte exp %0h got %0h", exp.out_byte, got.out_byte); errors++;
      end
      if (got.stream_kind !== exp.stream_kind) begin
        $error("stream_kind exp %0d got %0d", exp.stream_kind, got.stream_kind); errors++;
      end
      if (got.fork_last !== exp.fork_last) begin
        $error("fork_last exp %0d got %0d", exp.fork_last, got.fork_last); errors++;
      end
      if (got.header_end !== exp.header_end) begin
        $error("header_end exp %0d got %0d", exp.header_end, got.header_end); errors++;
      end
      if (got.header_valid !== exp.header_valid) begin
        $error("header_valid exp %0d got %0d", exp.header_valid, got.header_valid);
        errors++;
      end
      if (got.version_two !== exp.version_two) begin
        $error("version_two exp %0d got %0d", exp.version_two, got.version_two); errors++;
      end
      if (got.data_length !== exp.data_length) begin
        $error("data_length exp %0h got %0h", exp.data_length, got.data_length); errors++;
      end
      if (got.resource_length !== exp.resource_length) begin
        $error("resource_length exp %0h got %0h", exp.resource_length,
               got.resource_length);
        errors++;
      end
      if (got.secondary_flags !== exp.secondary_flags) begin
        $error("secondary_flags exp %0h got %0h", exp.secondary_flags,
               got.secondary_flags);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic        cfg_wdata = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [7:0]  in_in_byte = 0;
  logic        in_first_of_file = 0;
  logic        in_last_of_file = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [7:0]  out_out_byte;
  logic [1:0]  out_stream_kind;
  logic        out_fork_last;
  logic        out_header_end;
  logic        out_header_valid;
  logic        out_version_two;
  logic [31:0] out_data_length;
  logic [31:0] out_resource_length;
  logic [7:0]  out_secondary_flags;

  route_scoreboard sb = new();

  // Predictor state, mirrors the block's stream state.
  logic        pr_disable;
  stage_t      pr_stage;
  logic [7:0]  pr_pos;
  logic [15:0] pr_crc;
  logic        pr_fixed_ok;
  logic [15:0] pr_rx_crc;
  logic [7:0]  pr_ver, pr_min_ver, pr_flags;
  logic [31:0] pr_dlen, pr_rlen;
  logic [32:0] pr_off;

  logic quiet_tail = 0;
  int   accepted = 0;

  always #5 clk = ~clk;

  macbinary_stream_deframer dut (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .in_valid, .in_stall, .in_in_byte, .in_first_of_file, .in_last_of_file,
    .out_valid, .out_stall, .out_out_byte, .out_stream_kind, .out_fork_last,
    .out_header_end, .out_header_valid, .out_version_two, .out_data_length,
    .out_resource_length, .out_secondary_flags
  );

  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    repeat (8) r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
    return r;
  endfunction

  function automatic logic [32:0] pad_len(logic [31:0] len);
    logic [33:0] t;
    t = ({2'b0, len} + 34'd127) >> 7;
    return t[32:0] << 7;
  endfunction

  function automatic void clear_stream();
    pr_stage = ST_HEADER; pr_pos = 0; pr_crc = 0; pr_fixed_ok = 1; pr_rx_crc = 0;
    pr_ver = 0; pr_min_ver = 0; pr_flags = 0; pr_dlen = 0; pr_rlen = 0; pr_off = 0;
  endfunction

  // Pick the next nonempty fork, or done.
  function automatic void enter_fork(stage_t which);
    pr_off = 0;
    if (which == ST_DATA && pr_dlen != 0) pr_stage = ST_DATA;
    else if (which != ST_DONE && pr_rlen != 0) pr_stage = ST_RSRC;
    else pr_stage = ST_DONE;
  endfunction

  // Advance the predictor by one accepted byte; queue the item it routes.
  function automatic void predict_route(logic [7:0] b, logic first, logic last);
    result_t r;
    logic crc_ok, newer, ok;
    logic [31:0] len;
    r = '0;
    r.out_byte = b;
    if (first) clear_stream();
    if (pr_disable) begin
      r.stream_kind = KIND_RAW;
      sb.note_accept(r);
      return;
    end
    case (pr_stage)
      ST_HEADER: begin
        r.stream_kind = KIND_HDR;
        if (pr_pos < 124) pr_crc = crc_step(pr_crc, b);
        if (pr_pos == 0 || pr_pos == 74 || pr_pos == 82) begin
          if (b != 0) pr_fixed_ok = 0;
        end else if (pr_pos == 1) begin
          if (b < 1 || b >= 65) pr_fixed_ok = 0;
        end else if (pr_pos >= 83 && pr_pos <= 86) pr_dlen = {pr_dlen[23:0], b};
        else if (pr_pos >= 87 && pr_pos <= 90) pr_rlen = {pr_rlen[23:0], b};
        else if (pr_pos == 101) pr_flags = b;
        else if (pr_pos == 122) pr_ver = b;
        else if (pr_pos == 123) pr_min_ver = b;
        else if (pr_pos == 124 || pr_pos == 125) pr_rx_crc = {pr_rx_crc[7:0], b};
        if (pr_pos >= 127) begin
          crc_ok = (pr_crc == pr_rx_crc);
          newer = crc_ok && pr_ver > 128;
          ok = pr_fixed_ok && !(newer && pr_min_ver > 129);
          r.header_end = 1;
          r.header_valid = ok;
          r.version_two = ok && newer;
          r.data_length = pr_dlen;
          r.resource_length = pr_rlen;
          r.secondary_flags = (ok && newer) ? pr_flags : 8'h00;
          if (ok) enter_fork(ST_DATA);
          else pr_stage = ST_RAW;
        end else if (last) begin
          r.header_end = 1;
          pr_stage = ST_RAW;
        end
        pr_pos = pr_pos + 8'd1;
        sb.note_accept(r);
      end
      ST_DATA, ST_RSRC: begin
        len = (pr_stage == ST_DATA) ? pr_dlen : pr_rlen;
        if (pr_off < {1'b0, len}) begin
          r.stream_kind = (pr_stage == ST_DATA) ? KIND_DATA : KIND_RSRC;
          r.fork_last = (pr_off + 33'd1 == {1'b0, len});
          sb.note_accept(r);
        end
        pr_off = pr_off + 33'd1;
        if (pr_off >= pad_len(len))
          enter_fork(pr_stage == ST_DATA ? ST_RSRC : ST_DONE);
      end
      ST_RAW: begin
        r.stream_kind = KIND_RAW;
        sb.note_accept(r);
      end
      default: ;
    endcase
  endfunction

  // Receiver: random stall bursts, check every accepted item.
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_item({out_out_byte, out_stream_kind, out_fork_last, out_header_end,
                       out_header_valid, out_version_two, out_data_length,
                       out_resource_length, out_secondary_flags});
      if (burst > 0) burst--;
      else if (!quiet_tail && $urandom_range(0, 9) == 0) burst = $urandom_range(1, 13);
      out_stall <= (burst > 0);
    end
  end

  // Send one byte; hold it until accepted, idle at random before it.
  task automatic send_byte(logic [7:0] b, logic first, logic last);
    if (!quiet_tail && $urandom_range(0, 14) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1;
    in_in_byte <= b;
    in_first_of_file <= first;
    in_last_of_file <= last;
    do @(posedge clk); while (in_stall);
    predict_route(b, first, last);
    accepted++;
  endtask

  task automatic go_idle();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic v);
    go_idle();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    pr_disable = v;
  endtask

  // Build and send a file. mode: 0 good MacBinary, 1 bad CRC, 2 rejected
  // version, 3 broken fixed field, 4 random bytes. Fork sizes stay small.
  task automatic send_file(int mode, int dlen, int rlen, int extra);
    logic [7:0] hdr[128];
    logic [15:0] c;
    int total;
    for (int i = 0; i < 128; i++) hdr[i] = 8'($urandom);
    if (mode != 4) begin
      hdr[0] = 0; hdr[74] = 0; hdr[82] = 0;
      hdr[1] = 8'($urandom_range(1, 64));
      {hdr[83], hdr[84], hdr[85], hdr[86]} = dlen;
      {hdr[87], hdr[88], hdr[89], hdr[90]} = rlen;
      hdr[122] = (mode == 2) ? 8'($urandom_range(129, 255)) : 8'($urandom);
      hdr[123] = (mode == 2) ? 8'($urandom_range(130, 255)) : 8'($urandom_range(0, 129));
      if (mode == 3) begin
        case ($urandom_range(0, 4))
          0: hdr[0] = 8'($urandom_range(1, 255));
          1: hdr[74] = 8'($urandom_range(1, 255));
          2: hdr[82] = 8'($urandom_range(1, 255));
          3: hdr[1] = 0;
          default: hdr[1] = 8'($urandom_range(65, 255));
        endcase
      end
      c = 0;
      for (int i = 0; i < 124; i++) c = crc_step(c, hdr[i]);
      if (mode == 1) c = c ^ (16'd1 << $urandom_range(0, 15));
      {hdr[124], hdr[125]} = c;
    end
    total = 128 + ((dlen + 127) / 128) * 128 + ((rlen + 127) / 128) * 128 + extra;
    if (mode == 4) total = $urandom_range(1, 200);
    for (int i = 0; i < total; i++) begin
      send_byte(i < 128 ? hdr[i] : 8'($urandom), i == 0, i == total - 1);
    end
  endtask

  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    pr_disable = 0;
    clear_stream();
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes of the byte and flags, short file, every verdict.
    send_byte(8'h00, 1, 0);
    send_byte(8'hFF, 0, 1);
    send_byte(8'hA5, 0, 1);
    send_byte(8'h5A, 1, 1);
    send_file(0, 1, 0, 0);
    send_file(0, 0, 129, 3);
    send_file(0, 0, 0, 2);
    send_file(1, 5, 7, 0);
    send_file(2, 3, 3, 0);
    send_file(3, 2, 2, 0);
    write_cfg(1);
    send_byte(8'hFF, 1, 0);
    send_byte(8'h00, 0, 1);
    send_file(0, 4, 4, 0);
    write_cfg(0);
    send_byte(8'h11, 0, 0);  // stream was left mid-file while disabled
    send_file(0, 200, 130, 0);

    // Random files, mostly well-formed envelopes; stop early enough that the
    // last file lands near the target accepted-byte count.
    while (accepted < 1700) begin
      int m;
      if (accepted > 1450) quiet_tail = 1;
      m = $urandom_range(0, 9);
      if (m < 5) m = 0; else if (m < 7) m = 1; else if (m < 8) m = 2;
      else if (m < 9) m = 3; else m = 4;
      send_file(m, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 300),
                $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 300),
                $urandom_range(0, 5));
      if ($urandom_range(0, 7) == 0) go_idle();
      if (accepted > 900 && accepted < 1100 && !pr_disable && $urandom_range(0, 1)) begin
        write_cfg(1);
        send_file(4, 0, 0, 0);
        write_cfg(0);
      end
    end

    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
